// File: rtl/binary_semaphore_wait_queue_unit_core_macros.svh
// Assertion macros for the semaphore unit's RTL files.
// No dependencies; included by bswq_back, the file that carries assertions.
`ifndef BINARY_SEMAPHORE_WAIT_QUEUE_UNIT_CORE_MACROS_SVH
`define BINARY_SEMAPHORE_WAIT_QUEUE_UNIT_CORE_MACROS_SVH
`ifndef SYNTHESIS
// Checked on every clock edge outside reset.
`define BSWQ_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error(msg);
// Checked on every clock edge, reset included.
`define BSWQ_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define BSWQ_ASSERT(lbl, clk, rstn, prop, msg)
`define BSWQ_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

// File: rtl/bswq_pkg.sv
// Types and constants of the binary semaphore wait queue unit.
// No dependencies; used by the front, back and top level modules.
package bswq_pkg;

    localparam int OP_W        = 2;
    localparam int SEM_W       = 7;
    localparam int PID_W       = 8;
    localparam int SEM_SPACE   = 1 << SEM_W;
    localparam int IN_TDATA_W  = 24;
    localparam int OUT_TDATA_W = 16;

    typedef enum logic [OP_W-1:0] {
        OP_ACQUIRE = 2'd0,
        OP_RELEASE = 2'd1,
        OP_INIT    = 2'd2,
        OP_RSVD    = 2'd3
    } t_op;

    typedef enum logic [3:0] {
        ST_GRANTED       = 4'd0,
        ST_BLOCKED       = 4'd1,
        ST_FREED         = 4'd2,
        ST_HANDOFF       = 4'd3,
        ST_INIT          = 4'd4,
        ST_BAD_INDEX     = 4'd5,
        ST_NOT_HELD      = 4'd6,
        ST_OTHER_OWNER   = 4'd7,
        ST_OWNER_MISSING = 4'd8,
        ST_QUEUE_FULL    = 4'd9
    } t_status;

    // Request as it leaves the front end, already screened for bad index or reserved operation.
    typedef struct packed {
        t_op              op;
        logic [SEM_W-1:0] sem;
        logic [PID_W-1:0] pid;
        logic             val;
        logic             bad;
    } t_req;

    // Result beat, status in the lowest bits.
    typedef struct packed {
        logic [PID_W-1:0] woken_pid;
        logic             woken_valid;
        t_status          status;
    } t_result;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_EXEC = 3'b010,
        S_WAKE = 3'b100
    } t_bstate;

endpackage

// File: rtl/binary_semaphore_wait_queue_unit_core.sv
// Bank of binary semaphores, each with an owner and a FIFO ring of waiting process IDs.
// A request beat carries an acquire, release or initialize for one semaphore and gives
// exactly one result beat with a status code and, on a hand-off, the woken process ID.
// Requests are buffered two deep ahead of the execution unit, which takes a new request
// only when done with the last. It first does the registered read of the semaphore record,
// then updates it and loads the result register once that register is free. A release that
// hands the semaphore to a waiter adds a dependent read of the wait-ring memory in between.
// No clearing pass is needed after reset; records never written read as free with no
// owner and an empty ring. Depends on bswq_pkg, bswq_front, bswq_back and bswq_ram.
module binary_semaphore_wait_queue_unit_core #(
    parameter int NUM_SEMAPHORES = 128,
    parameter int QUEUE_DEPTH    = 64
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_s_tvalid,
    output logic                             o_s_tready,
    // [1:0] operation, [8:2] sem_index, [16:9] process_id, [17] init_value
    input  logic [bswq_pkg::IN_TDATA_W-1:0]  i_s_tdata,
    output logic                             o_m_tvalid,
    input  logic                             i_m_tready,
    // [3:0] status, [4] woken_valid, [12:5] woken_pid
    output logic [bswq_pkg::OUT_TDATA_W-1:0] o_m_tdata
);

    logic           req_valid;
    bswq_pkg::t_req req;
    logic           req_pop;

    bswq_front #(
        .NUM_SEMAPHORES (NUM_SEMAPHORES)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .o_req_valid (req_valid),
        .o_req       (req),
        .i_req_pop   (req_pop)
    );

    bswq_back #(
        .NUM_SEMAPHORES (NUM_SEMAPHORES),
        .QUEUE_DEPTH    (QUEUE_DEPTH)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (req_valid),
        .i_req       (req),
        .o_req_pop   (req_pop),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata)
    );

endmodule

// File: rtl/bswq_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// No dependencies; holds the semaphore records and the wait rings.
module bswq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: rtl/bswq_front.sv
// Front end: accepts request beats, flags bad ones and buffers them.
// Depends on bswq_pkg.
module bswq_front #(
    parameter int NUM_SEMAPHORES = 128
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_s_tvalid,
    output logic                               o_s_tready,
    input  logic [bswq_pkg::IN_TDATA_W-1:0]    i_s_tdata,
    output logic                               o_req_valid,
    output bswq_pkg::t_req                     o_req,
    input  logic                               i_req_pop
);

    bswq_pkg::t_req r_buf [2];
    bswq_pkg::t_req in_req;
    logic           r_wp, n_wp;
    logic           r_rp, n_rp;
    logic [1:0]     r_cnt, n_cnt;
    logic           push;
    logic           pop;

    always_comb begin
        in_req.op  = bswq_pkg::t_op'(i_s_tdata[1:0]);
        in_req.sem = i_s_tdata[8:2];
        in_req.pid = i_s_tdata[16:9];
        in_req.val = i_s_tdata[17];
        // The unused operation code is reported the same way as a bad index.
        in_req.bad = (in_req.op == bswq_pkg::OP_RSVD)
                     || (int'(in_req.sem) >= NUM_SEMAPHORES);
    end

    assign o_s_tready  = (r_cnt != 2'd2);
    assign o_req_valid = (r_cnt != 2'd0);
    assign o_req       = r_buf[r_rp];
    assign push        = i_s_tvalid && o_s_tready;
    assign pop         = i_req_pop && o_req_valid;

    always_comb begin
        n_wp  = push ? ~r_wp : r_wp;
        n_rp  = pop ? ~r_rp : r_rp;
        n_cnt = r_cnt + 2'(push) - 2'(pop);
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_buf[r_wp] <= in_req;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

endmodule

// File: rtl/bswq_back.sv
// Back end: read-modify-write of the semaphore record and wait ring.
// Depends on bswq_pkg, bswq_ram and the assertion macro header.
`include "binary_semaphore_wait_queue_unit_core_macros.svh"
module bswq_back #(
    parameter int NUM_SEMAPHORES = 128,
    parameter int QUEUE_DEPTH    = 64
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_req_valid,
    input  bswq_pkg::t_req                   i_req,
    output logic                             o_req_pop,
    output logic                             o_m_tvalid,
    input  logic                             i_m_tready,
    output logic [bswq_pkg::OUT_TDATA_W-1:0] o_m_tdata
);

    localparam int SEM_DEPTH  = (NUM_SEMAPHORES < bswq_pkg::SEM_SPACE)
                                ? NUM_SEMAPHORES : bswq_pkg::SEM_SPACE;
    localparam int SEM_AW     = $clog2(SEM_DEPTH);
    localparam int SLOT_W     = $clog2(QUEUE_DEPTH);
    localparam int CNT_W      = $clog2(QUEUE_DEPTH + 1);
    localparam int SUM_W      = CNT_W + 1;
    localparam int RING_DEPTH = SEM_DEPTH << SLOT_W;
    localparam int RING_AW    = SEM_AW + SLOT_W;

    typedef struct packed {
        logic                       free;
        logic                       own_v;
        logic [bswq_pkg::PID_W-1:0] own_pid;
        logic [SLOT_W-1:0]          head;
        logic [CNT_W-1:0]           cnt;
    } t_rec;

    localparam int   REC_W     = $bits(t_rec);
    localparam t_rec REC_RESET = '{free: 1'b1, own_v: 1'b0, own_pid: '0,
                                   head: '0, cnt: '0};

    bswq_pkg::t_bstate r_state, n_state;
    bswq_pkg::t_req    r_cur, n_cur;
    bswq_pkg::t_result r_out, n_out;
    t_rec              r_rec, n_rec;
    logic              r_out_valid, n_out_valid;
    logic [SEM_DEPTH-1:0] r_vld;

    logic [SEM_AW-1:0]          cur_idx;
    logic [REC_W-1:0]           rec_rdata;
    t_rec                       rec_now;
    t_rec                       wake_rec;
    logic                       st_re, st_we;
    t_rec                       st_wdata;
    logic                       ring_re, ring_we;
    logic [bswq_pkg::PID_W-1:0] ring_rdata;
    logic [SUM_W-1:0]           tail_sum;
    logic [SLOT_W-1:0]          tail;
    logic [SLOT_W-1:0]          head_next;
    logic                       out_free;

    t_rec              ex_rec;
    logic              ex_write, ex_ring_we, ex_wake;
    bswq_pkg::t_status ex_status;

    assign cur_idx = r_cur.sem[SEM_AW-1:0];

    // Records never written since reset read as the reset record.
    assign rec_now = r_vld[cur_idx] ? t_rec'(rec_rdata) : REC_RESET;

    assign tail_sum = SUM_W'(rec_now.head) + SUM_W'(rec_now.cnt);
    assign tail     = (tail_sum >= SUM_W'(QUEUE_DEPTH))
                      ? SLOT_W'(tail_sum - SUM_W'(QUEUE_DEPTH)) : SLOT_W'(tail_sum);
    assign head_next = (r_rec.head == SLOT_W'(QUEUE_DEPTH - 1))
                       ? '0 : r_rec.head + 1'b1;

    always_comb begin
        wake_rec         = r_rec;
        wake_rec.own_pid = ring_rdata;
        wake_rec.own_v   = 1'b1;
        wake_rec.head    = head_next;
        wake_rec.cnt     = r_rec.cnt - 1'b1;
    end

    // Decision on the record just read.
    always_comb begin
        ex_rec     = rec_now;
        ex_write   = 1'b0;
        ex_ring_we = 1'b0;
        ex_wake    = 1'b0;
        ex_status  = bswq_pkg::ST_BAD_INDEX;
        if (!r_cur.bad) begin
            unique case (r_cur.op)
                bswq_pkg::OP_ACQUIRE: begin
                    priority if (rec_now.free) begin
                        ex_rec.free    = 1'b0;
                        ex_rec.own_pid = r_cur.pid;
                        ex_rec.own_v   = 1'b1;
                        ex_write       = 1'b1;
                        ex_status      = bswq_pkg::ST_GRANTED;
                    end else if (rec_now.cnt == CNT_W'(QUEUE_DEPTH)) begin
                        ex_status = bswq_pkg::ST_QUEUE_FULL;
                    end else begin
                        ex_rec.cnt = rec_now.cnt + 1'b1;
                        ex_write   = 1'b1;
                        ex_ring_we = 1'b1;
                        ex_status  = bswq_pkg::ST_BLOCKED;
                    end
                end
                bswq_pkg::OP_RELEASE: begin
                    priority if (rec_now.free) begin
                        ex_status = bswq_pkg::ST_NOT_HELD;
                    end else if (!rec_now.own_v) begin
                        ex_status = bswq_pkg::ST_OWNER_MISSING;
                    end else if (rec_now.own_pid != r_cur.pid) begin
                        ex_status = bswq_pkg::ST_OTHER_OWNER;
                    end else if (rec_now.cnt == '0) begin
                        ex_rec.free    = 1'b1;
                        ex_rec.own_v   = 1'b0;
                        ex_rec.own_pid = '0;
                        ex_write       = 1'b1;
                        ex_status      = bswq_pkg::ST_FREED;
                    end else begin
                        ex_wake   = 1'b1;
                        ex_status = bswq_pkg::ST_HANDOFF;
                    end
                end
                bswq_pkg::OP_INIT: begin
                    ex_rec.free = r_cur.val;
                    ex_write    = 1'b1;
                    ex_status   = bswq_pkg::ST_INIT;
                end
                bswq_pkg::OP_RSVD: begin
                    ex_status = bswq_pkg::ST_BAD_INDEX;
                end
            endcase
        end
    end

    assign out_free = !r_out_valid || i_m_tready;

    always_comb begin
        n_state     = r_state;
        n_cur       = r_cur;
        n_rec       = r_rec;
        n_out       = r_out;
        n_out_valid = r_out_valid && !i_m_tready;
        o_req_pop   = 1'b0;
        st_re       = 1'b0;
        st_we       = 1'b0;
        st_wdata    = ex_rec;
        ring_re     = 1'b0;
        ring_we     = 1'b0;
        unique case (r_state)
            bswq_pkg::S_IDLE: begin
                if (i_req_valid) begin
                    o_req_pop = 1'b1;
                    n_cur     = i_req;
                    st_re     = 1'b1;
                    n_state   = bswq_pkg::S_EXEC;
                end
            end
            bswq_pkg::S_EXEC: begin
                // A hand-off needs the oldest waiter, so the ring is read first.
                if (ex_wake) begin
                    ring_re = 1'b1;
                    n_rec   = rec_now;
                    n_state = bswq_pkg::S_WAKE;
                end else if (out_free) begin
                    st_we       = ex_write;
                    ring_we     = ex_ring_we;
                    n_out       = '{woken_pid: '0, woken_valid: 1'b0, status: ex_status};
                    n_out_valid = 1'b1;
                    n_state     = bswq_pkg::S_IDLE;
                end
            end
            bswq_pkg::S_WAKE: begin
                if (out_free) begin
                    st_we       = 1'b1;
                    st_wdata    = wake_rec;
                    n_out       = '{woken_pid: ring_rdata, woken_valid: 1'b1,
                                    status: bswq_pkg::ST_HANDOFF};
                    n_out_valid = 1'b1;
                    n_state     = bswq_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = bswq_pkg::S_IDLE;
            end
        endcase
    end

    bswq_ram #(
        .WIDTH (REC_W),
        .DEPTH (SEM_DEPTH)
    ) u_rec_ram (
        .i_clk   (i_clk),
        .i_we    (st_we),
        .i_waddr (cur_idx),
        .i_wdata (st_wdata),
        .i_re    (st_re),
        .i_raddr (i_req.sem[SEM_AW-1:0]),
        .o_rdata (rec_rdata)
    );

    bswq_ram #(
        .WIDTH (bswq_pkg::PID_W),
        .DEPTH (RING_DEPTH)
    ) u_ring_ram (
        .i_clk   (i_clk),
        .i_we    (ring_we),
        .i_waddr (RING_AW'({cur_idx, tail})),
        .i_wdata (r_cur.pid),
        .i_re    (ring_re),
        .i_raddr (RING_AW'({cur_idx, rec_now.head})),
        .o_rdata (ring_rdata)
    );

    always_ff @(posedge i_clk) begin
        r_cur <= n_cur;
        r_rec <= n_rec;
        r_out <= n_out;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= bswq_pkg::S_IDLE;
            r_out_valid <= 1'b0;
            r_vld       <= '0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            if (st_we) begin
                r_vld[cur_idx] <= 1'b1;
            end
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = bswq_pkg::OUT_TDATA_W'(r_out);

    `BSWQ_ASSERT_ALWAYS(a_reset_idle, i_clk,
        !i_rst_n |=> (r_state == bswq_pkg::S_IDLE && !r_out_valid),
        "back end not idle after reset")
    `BSWQ_ASSERT(a_result_source, i_clk, i_rst_n,
        $rose(r_out_valid) |-> ($past(r_state) == bswq_pkg::S_EXEC
            || $past(r_state) == bswq_pkg::S_WAKE),
        "result appeared outside execution")
    `BSWQ_ASSERT(a_wake_path, i_clk, i_rst_n,
        (r_state == bswq_pkg::S_WAKE) |-> (r_cur.op == bswq_pkg::OP_RELEASE
            && ($past(r_state) == bswq_pkg::S_EXEC || $past(r_state) == bswq_pkg::S_WAKE)),
        "wake state entered without a release")
    `BSWQ_ASSERT(a_woken_flag, i_clk, i_rst_n,
        r_out_valid |-> (r_out.woken_valid == (r_out.status == bswq_pkg::ST_HANDOFF)),
        "woken flag disagrees with status")

endmodule
